>>> hw/rtl/ipp_pkg.sv
// ----------------------------------------------------------------------------
// IMU packet parser package
// Packet kinds, queue entry layout, scale factors and temperature constants.
// ----------------------------------------------------------------------------
package ipp_pkg;

   // packet kind, given by position within the 44-byte frame
   typedef enum logic [1:0] {
      KIND_ACCEL = 2'd0,
      KIND_GYRO  = 2'd1,
      KIND_ANGLE = 2'd2,
      KIND_MAG   = 2'd3
   } kind_type;

   // offsets within an 11-byte packet
   localparam logic [3:0] OFF_FIRST     = 4'd0;
   localparam logic [3:0] OFF_PAY_FIRST = 4'd2;
   localparam logic [3:0] OFF_PAY_LAST  = 4'd9;
   localparam logic [3:0] OFF_CHECKSUM  = 4'd10;

   // packet_enable reset value: angle packets only
   localparam logic [3:0] ENABLE_RESET = 4'b0100;

   // Q16.16 scale factors per kind
   localparam logic [16:0] SCALE_ACCEL = 17'd32;
   localparam logic [16:0] SCALE_GYRO  = 17'd4000;
   localparam logic [16:0] SCALE_ANGLE = 17'd360;
   localparam logic [16:0] SCALE_MAG   = 17'd65536;

   // temperature: round(|s| * 65536 / 100) = ((|s| << 16) + 50) * MAGIC >> 37
   localparam logic [31:0] TEMP_BIAS  = 32'd50;
   localparam logic [31:0] TEMP_MAGIC = 32'h51EB_851F;
   localparam int          TEMP_SHIFT = 37;

   // one parsed packet handed from front to back
   typedef struct packed {
      kind_type         kind;
      logic             csum_ok;
      logic [3:0][15:0] words;
   } pkt_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> hw/rtl/ipp_req_if.sv
// ----------------------------------------------------------------------------
// IMU packet parser byte channel
// Valid/ready channel carrying one received byte and its frame start mark.
// ----------------------------------------------------------------------------
interface ipp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

>>> hw/rtl/ipp_rsp_if.sv
// ----------------------------------------------------------------------------
// IMU packet parser result channel
// Valid/ready channel carrying one decoded packet.
// ----------------------------------------------------------------------------
interface ipp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         packet_kind;
   logic               checksum_ok;
   logic signed [31:0] axis_x;
   logic signed [31:0] axis_y;
   logic signed [31:0] axis_z;
   logic signed [31:0] aux_value;

   modport source (output valid, output packet_kind, output checksum_ok,
                   output axis_x, output axis_y, output axis_z, output aux_value,
                   input ready);
   modport sink   (input valid, input packet_kind, input checksum_ok,
                   input axis_x, input axis_y, input axis_z, input aux_value,
                   output ready);
endinterface

>>> hw/rtl/imu_packet_parser_top.sv
// ----------------------------------------------------------------------------
// IMU packet parser top level
// Parses 44-byte IMU frames (accel, gyro, angle, magnetic) into scaled results.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  : one byte per transfer; frame_start marks frame byte 0. Without
//             it, the position wraps after byte 43.
//   rsp_if  : one result per enabled packet, sent after that packet's
//             checksum byte: kind, checksum flag, three Q16.16 axes and aux.
//   csr_*   : write packet_enable (bit per kind), only while idle.
// Throughput: one byte per cycle while the queue is not full.
// Path: after the transfer of its checksum byte, a result passes through the
//   queue, the product stage and the division-by-100 stage into the output register.
// Reset: position, checksum and queue clear; packet_enable returns to angle
//   packets only; no result is pending.
// Stall: a held result blocks the pipeline; the queue of QUEUE_DEPTH packets
//   keeps absorbing bytes, and req_if.ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module imu_packet_parser_top
   import ipp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   ipp_req_if.sink    req_if,
   ipp_rsp_if.source  rsp_if,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);

   logic         xfer;
   logic         push;
   logic         pop;
   pkt_type      push_pkt;
   pkt_type      head_pkt;
   q_status_type q_status;

   // input transfer while the queue has room
   assign req_if.ready = !q_status.full;
   assign xfer         = req_if.valid && req_if.ready;

   ipp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .xfer        (xfer),
      .data_byte   (req_if.data_byte),
      .frame_start (req_if.frame_start),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .push_pkt    (push_pkt)
   );

   ipp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_pkt (push_pkt),
      .pop      (pop),
      .head_pkt (head_pkt),
      .status   (q_status)
   );

   ipp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_pkt (head_pkt),
      .q_status (q_status),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

   // no packet record is pushed into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("packet pushed into full queue");

   // an empty queue with no push stays empty
   a_empty_holds: assert property (@(posedge clock) disable iff (reset)
      (q_status.empty && !push) |=> q_status.empty)
      else $error("queue left empty state without a push");

   // no result directly after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("result valid right after reset");

endmodule

>>> hw/rtl/ipp_front.sv
// ----------------------------------------------------------------------------
// IMU packet parser front end
// Tracks frame position, running checksum and payload bytes; pushes one
// packet record per enabled packet into the queue.
// ----------------------------------------------------------------------------
module ipp_front
   import ipp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         xfer,
   input  logic [7:0]   data_byte,
   input  logic         frame_start,
   input  logic         csr_wr_en,
   input  logic [3:0]   csr_wr_data,
   output logic         push,
   output pkt_type      push_pkt
);

   logic [3:0]       enable_ff;
   logic [3:0]       off_ff, off_in;
   kind_type         kind_ff, kind_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       pay_ff [8];
   logic [3:0]       off_now;
   kind_type         kind_now;
   logic [3:0]       pay_idx;

   // position of the current byte; frame start restarts at accel byte 0
   assign off_now  = frame_start ? OFF_FIRST : off_ff;
   assign kind_now = frame_start ? KIND_ACCEL : kind_ff;
   assign pay_idx  = off_now - OFF_PAY_FIRST;

   // next position and running sum
   always_comb begin
      if (off_now == OFF_CHECKSUM) begin
         off_in  = OFF_FIRST;
         kind_in = kind_type'(kind_now + 2'd1);
      end else begin
         off_in  = off_now + 4'd1;
         kind_in = kind_now;
      end
      if (off_now == OFF_FIRST) begin
         sum_in = data_byte;
      end else begin
         sum_in = sum_ff + data_byte;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= ENABLE_RESET;
         off_ff    <= OFF_FIRST;
         kind_ff   <= KIND_ACCEL;
         sum_ff    <= 8'd0;
      end else begin
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
         if (xfer) begin
            off_ff  <= off_in;
            kind_ff <= kind_in;
            sum_ff  <= sum_in;
         end
      end
   end

   // payload bytes 2..9
   always_ff @(posedge clock) begin
      if (xfer && off_now >= OFF_PAY_FIRST && off_now <= OFF_PAY_LAST) begin
         pay_ff[pay_idx[2:0]] <= data_byte;
      end
   end

   // packet record on the checksum byte
   always_comb begin
      push             = xfer && (off_now == OFF_CHECKSUM) && enable_ff[kind_now];
      push_pkt.kind    = kind_now;
      push_pkt.csum_ok = (sum_ff == data_byte);
      for (int i = 0; i < 4; i++) begin
         push_pkt.words[i] = {pay_ff[2*i+1], pay_ff[2*i]};
      end
   end

endmodule

>>> hw/rtl/ipp_queue.sv
// ----------------------------------------------------------------------------
// IMU packet parser queue
// Small FIFO of packet records between front end and back end.
// ----------------------------------------------------------------------------
module ipp_queue
   import ipp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  pkt_type      push_pkt,
   input  logic         pop,
   output pkt_type      head_pkt,
   output q_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   pkt_type       mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign head_pkt     = mem[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_pkt;
      end
   end

endmodule

>>> hw/rtl/ipp_back.sv
// ----------------------------------------------------------------------------
// IMU packet parser back end
// Two-stage scaling pipeline: axis products and temperature numerator, then
// constant division by 100 and aux selection into the output register.
// ----------------------------------------------------------------------------
module ipp_back
   import ipp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pkt_type      head_pkt,
   input  q_status_type q_status,
   output logic         pop,
   ipp_rsp_if.source    rsp_if
);

   // stage 1 registers
   logic               s1_valid_ff;
   kind_type           s1_kind_ff;
   logic               s1_ok_ff;
   logic signed [31:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic [31:0]        s1_num_ff;
   logic               s1_neg_ff;
   logic [15:0]        s1_w3_ff;

   // stage 2 (output) registers
   logic               s2_valid_ff;
   logic [1:0]         s2_kind_ff;
   logic               s2_ok_ff;
   logic signed [31:0] s2_x_ff, s2_y_ff, s2_z_ff, s2_aux_ff;

   logic               adv1, adv2;
   logic [16:0]        scale;
   logic signed [33:0] prod_x, prod_y, prod_z;
   logic [15:0]        mag3;
   logic [31:0]        num_in;
   logic [63:0]        temp_prod;
   logic [31:0]        temp_abs, temp_q;
   logic [31:0]        aux_in;

   // pipeline flow
   assign adv2 = !s2_valid_ff || rsp_if.ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign pop  = !q_status.empty && adv1;

   // stage 1: scale select, axis products and temperature numerator
   always_comb begin
      case (head_pkt.kind)
         KIND_ACCEL: scale = SCALE_ACCEL;
         KIND_GYRO:  scale = SCALE_GYRO;
         KIND_ANGLE: scale = SCALE_ANGLE;
         KIND_MAG:   scale = SCALE_MAG;
         default:    scale = SCALE_MAG;
      endcase
      prod_x = $signed(head_pkt.words[0]) * $signed({1'b0, scale});
      prod_y = $signed(head_pkt.words[1]) * $signed({1'b0, scale});
      prod_z = $signed(head_pkt.words[2]) * $signed({1'b0, scale});
      mag3   = head_pkt.words[3][15] ? (16'd0 - head_pkt.words[3]) : head_pkt.words[3];
      num_in = {mag3, 16'd0} + TEMP_BIAS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_kind_ff <= head_pkt.kind;
         s1_ok_ff   <= head_pkt.csum_ok;
         s1_x_ff    <= prod_x[31:0];
         s1_y_ff    <= prod_y[31:0];
         s1_z_ff    <= prod_z[31:0];
         s1_num_ff  <= num_in;
         s1_neg_ff  <= head_pkt.words[3][15];
         s1_w3_ff   <= head_pkt.words[3];
      end
   end

   // stage 2: divide by 100 via reciprocal, restore sign, pick aux
   always_comb begin
      temp_prod = s1_num_ff * TEMP_MAGIC;
      temp_abs  = {5'd0, temp_prod[63:TEMP_SHIFT]};
      temp_q    = s1_neg_ff ? (32'd0 - temp_abs) : temp_abs;
      case (s1_kind_ff)
         KIND_ACCEL: aux_in = temp_q;
         KIND_GYRO:  aux_in = 32'd0;
         KIND_ANGLE: aux_in = {16'd0, s1_w3_ff};
         KIND_MAG:   aux_in = temp_q;
         default:    aux_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         s2_kind_ff <= s1_kind_ff;
         s2_ok_ff   <= s1_ok_ff;
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_z_ff    <= s1_z_ff;
         s2_aux_ff  <= aux_in;
      end
   end

   // result channel
   assign rsp_if.valid       = s2_valid_ff;
   assign rsp_if.packet_kind = s2_kind_ff;
   assign rsp_if.checksum_ok = s2_ok_ff;
   assign rsp_if.axis_x      = s2_x_ff;
   assign rsp_if.axis_y      = s2_y_ff;
   assign rsp_if.axis_z      = s2_z_ff;
   assign rsp_if.aux_value   = s2_aux_ff;

endmodule
